FILE: src/wstd_pkg.sv
// Package for the work stealing task dispatcher: sizes, status codes, payload structs.
// No dependencies.
package wstd_pkg;
  localparam int unsigned MaxWorkers    = 8;
  localparam int unsigned LocalDepth    = 128;
  localparam int unsigned OverflowDepth = 256;
  localparam int unsigned WidW  = $clog2(MaxWorkers);
  localparam int unsigned WidL  = $clog2(LocalDepth);
  localparam int unsigned WidO  = $clog2(OverflowDepth);
  localparam int unsigned TaskW = 51;

  typedef enum logic [2:0] {
    StLocalPush = 3'd0,
    StOvfPush   = 3'd1,
    StRejected  = 3'd2,
    StOwnPop    = 3'd3,
    StOvfPop    = 3'd4,
    StStolen    = 3'd5,
    StNone      = 3'd6
  } status_e;

  localparam logic OpSubmit = 1'b0;
  localparam logic OpFetch  = 1'b1;

  typedef struct packed {
    logic [15:0] task_function;
    logic [31:0] task_argument;
    logic [2:0]  stage;
  } task_t;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  worker_id;
    logic [15:0] task_function;
    logic [31:0] task_argument;
    logic [2:0]  stage;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] task_function_res;
    logic [31:0] task_argument_res;
    logic [2:0]  stage_res;
    logic [8:0]  queue_depth;
  } rsp_t;

  // Memory access command from the controller.
  typedef struct packed {
    logic               we;
    logic               re;
    logic [WidW+WidL-1:0] addr;
    task_t              wdata;
  } lmem_cmd_t;

  typedef struct packed {
    logic            we;
    logic            re;
    logic [WidO-1:0] addr;
    task_t           wdata;
  } omem_cmd_t;
endpackage

FILE: src/wstd_ram.sv
// Single-port synchronous RAM with registered read.
// Uses wstd_pkg::task_t.
module wstd_ram #(
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  wstd_pkg::task_t          wdata_i,
  output wstd_pkg::task_t          rdata_o
);
  wstd_pkg::task_t mem [Depth];
  wstd_pkg::task_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: src/wstd_ctrl.sv
// Ring pointer control: decides each request, issues memory commands, forms result.
// Uses wstd_pkg; pointers live in flip-flops, task data in external RAMs.
module wstd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  wstd_pkg::req_t      req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output wstd_pkg::rsp_t      rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [3:0]          cfg_data_i,
  output wstd_pkg::lmem_cmd_t lcmd_o,
  output wstd_pkg::omem_cmd_t ocmd_o,
  input  wstd_pkg::task_t     lrdata_i,
  input  wstd_pkg::task_t     ordata_i
);
  localparam int unsigned W = wstd_pkg::WidW;
  localparam int unsigned L = wstd_pkg::WidL;
  localparam int unsigned O = wstd_pkg::WidO;

  typedef enum logic [1:0] {SIdle, SRead, SOut} state_e;
  typedef enum logic [1:0] {SrcZero, SrcLocal, SrcOvf} src_e;

  state_e         state_q, state_d;
  src_e           src_q, src_d;
  logic [3:0]     nw_q;
  logic [L-1:0]   head_q  [wstd_pkg::MaxWorkers];
  logic [L:0]     count_q [wstd_pkg::MaxWorkers];
  logic [O-1:0]   ohead_q;
  logic [O:0]     ocount_q;
  wstd_pkg::rsp_t rsp_q, rsp_d;

  logic [W:0] active;
  always_comb begin
    if (nw_q == 4'd0) active = (W+1)'(1);
    else if ({28'd0, nw_q} > wstd_pkg::MaxWorkers) active = (W+1)'(wstd_pkg::MaxWorkers);
    else active = (W+1)'(nw_q);
  end

  // Lowest-numbered active non-empty victim other than the requester.
  logic         vic_found;
  logic [W-1:0] vic;
  always_comb begin
    vic_found = 1'b0;
    vic = '0;
    for (int v = wstd_pkg::MaxWorkers - 1; v >= 0; v--) begin
      if ((W+1)'(v) < active && W'(v) != req_i.worker_id && count_q[v] != '0) begin
        vic_found = 1'b1;
        vic = W'(v);
      end
    end
  end

  logic         acc;
  logic [W-1:0] wid;
  logic         wact;
  assign acc  = req_valid_i && req_ready_o;
  assign wid  = req_i.worker_id[W-1:0];
  assign wact = {1'b0, req_i.worker_id} < 4'(active);

  assign req_ready_o = state_q == SIdle;
  assign cfg_ready_o = state_q == SIdle;
  assign rsp_valid_o = state_q == SOut;
  assign rsp_o       = rsp_q;

  wstd_pkg::task_t newt;
  assign newt = '{req_i.task_function, req_i.task_argument, req_i.stage};

  always_comb begin
    state_d = state_q;
    src_d   = src_q;
    rsp_d   = rsp_q;
    lcmd_o  = '0;
    ocmd_o  = '0;
    lcmd_o.wdata = newt;
    ocmd_o.wdata = newt;
    unique case (state_q)
      SIdle: begin
        if (acc) begin
          rsp_d = '0;
          src_d = SrcZero;
          state_d = SRead;
          if (!wact) begin
            rsp_d.status = (req_i.opcode == wstd_pkg::OpSubmit) ?
                           3'(wstd_pkg::StRejected) : 3'(wstd_pkg::StNone);
          end else if (req_i.opcode == wstd_pkg::OpSubmit) begin
            if (count_q[wid] < (L+1)'(wstd_pkg::LocalDepth)) begin
              lcmd_o.we   = 1'b1;
              lcmd_o.addr = {wid, L'(head_q[wid] + count_q[wid][L-1:0])};
              rsp_d.status = 3'(wstd_pkg::StLocalPush);
              rsp_d.queue_depth = 9'(count_q[wid]);
            end else if (ocount_q < (O+1)'(wstd_pkg::OverflowDepth)) begin
              ocmd_o.we   = 1'b1;
              ocmd_o.addr = O'(ohead_q + ocount_q[O-1:0]);
              rsp_d.status = 3'(wstd_pkg::StOvfPush);
              rsp_d.queue_depth = 9'(ocount_q);
            end else begin
              rsp_d.status = 3'(wstd_pkg::StRejected);
              rsp_d.queue_depth = 9'(ocount_q);
            end
          end else if (count_q[wid] != '0) begin
            lcmd_o.re   = 1'b1;
            lcmd_o.addr = {wid, L'(head_q[wid] + L'(count_q[wid] - 1'b1))};
            rsp_d.status = 3'(wstd_pkg::StOwnPop);
            src_d = SrcLocal;
          end else if (ocount_q != '0) begin
            ocmd_o.re   = 1'b1;
            ocmd_o.addr = ohead_q;
            rsp_d.status = 3'(wstd_pkg::StOvfPop);
            src_d = SrcOvf;
          end else if (vic_found) begin
            lcmd_o.re   = 1'b1;
            lcmd_o.addr = {vic, head_q[vic]};
            rsp_d.status = 3'(wstd_pkg::StStolen);
            src_d = SrcLocal;
          end else begin
            rsp_d.status = 3'(wstd_pkg::StNone);
          end
        end
      end
      SRead: begin
        // Read data lands now; capture into the output register.
        case (src_q)
          SrcLocal: {rsp_d.task_function_res, rsp_d.task_argument_res, rsp_d.stage_res} = lrdata_i;
          SrcOvf:   {rsp_d.task_function_res, rsp_d.task_argument_res, rsp_d.stage_res} = ordata_i;
          default: ;
        endcase
        state_d = SOut;
      end
      SOut: begin
        if (rsp_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      src_q    <= SrcZero;
      nw_q     <= 4'd8;
      ohead_q  <= '0;
      ocount_q <= '0;
      rsp_q    <= '0;
      for (int i = 0; i < wstd_pkg::MaxWorkers; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      src_q   <= src_d;
      rsp_q   <= rsp_d;
      if (cfg_valid_i && cfg_ready_o) nw_q <= cfg_data_i;
      if (acc) begin
        if (lcmd_o.we) count_q[wid] <= count_q[wid] + 1'b1;
        if (ocmd_o.we) ocount_q <= ocount_q + 1'b1;
        if (rsp_d.status == 3'(wstd_pkg::StOwnPop)) count_q[wid] <= count_q[wid] - 1'b1;
        if (rsp_d.status == 3'(wstd_pkg::StOvfPop)) begin
          ohead_q  <= ohead_q + 1'b1;
          ocount_q <= ocount_q - 1'b1;
        end
        if (rsp_d.status == 3'(wstd_pkg::StStolen)) begin
          head_q[vic]  <= head_q[vic] + 1'b1;
          count_q[vic] <= count_q[vic] - 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocount_q <= (O+1)'(wstd_pkg::OverflowDepth))
    else $error("overflow count above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(lcmd_o.we && ocmd_o.we))
    else $error("submit wrote both rings");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> state_q == SRead)
    else $error("accepted request skipped read cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_ready_i) |=> $stable(rsp_q))
    else $error("stalled result changed");
endmodule

FILE: src/work_stealing_task_dispatcher_core.sv
// Work stealing task dispatcher: one request channel, one result channel and a
// num_workers write port. A request is a submit or a fetch of one worker.
// A request is accepted when req_valid_i and req_ready_o are high. The ring
// pointers are updated at once; the task RAM is written or read in that cycle,
// its registered read data is captured the next cycle, and the result shows on
// rsp_valid_o in the SOut state. A request is finished before the next one is
// taken. A fetch searches the worker's own ring, then the overflow ring, then
// the lowest-numbered other active worker. While the receiver holds rsp_ready_i
// low the result stays registered and no new request is taken. Reset empties
// all rings at once (counts and heads clear; the RAMs need no clearing) and
// sets num_workers to 8.
// cfg_ready_o is high only when no request is in flight.
// Uses wstd_pkg, wstd_ctrl and wstd_ram.
module work_stealing_task_dispatcher_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  wstd_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output wstd_pkg::rsp_t rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [3:0]     cfg_data_i
);
  wstd_pkg::lmem_cmd_t lcmd;
  wstd_pkg::omem_cmd_t ocmd;
  wstd_pkg::task_t     lrdata, ordata;

  wstd_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_i,
    .rsp_valid_o, .rsp_ready_i, .rsp_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .lcmd_o(lcmd), .ocmd_o(ocmd), .lrdata_i(lrdata), .ordata_i(ordata)
  );

  wstd_ram #(.Depth(wstd_pkg::MaxWorkers * wstd_pkg::LocalDepth)) u_lram (
    .clk_i, .we_i(lcmd.we), .re_i(lcmd.re), .addr_i(lcmd.addr),
    .wdata_i(lcmd.wdata), .rdata_o(lrdata)
  );

  wstd_ram #(.Depth(wstd_pkg::OverflowDepth)) u_oram (
    .clk_i, .we_i(ocmd.we), .re_i(ocmd.re), .addr_i(ocmd.addr),
    .wdata_i(ocmd.wdata), .rdata_o(ordata)
  );
endmodule

FILE: tb/tb.sv
// Self-checking bench for work_stealing_task_dispatcher_core: request driver, result
// monitor and an in-bench model of the worker rings, the overflow ring and stealing.
// Depends on wstd_pkg and the dispatcher RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n;
  logic req_valid, req_ready, rsp_valid, rsp_ready, cfg_valid, cfg_ready;
  wstd_pkg::req_t req;
  wstd_pkg::rsp_t rsp;
  logic [3:0] cfg_data;

  work_stealing_task_dispatcher_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .req_valid_i(req_valid), .req_ready_o(req_ready), .req_i(req),
    .rsp_valid_o(rsp_valid), .rsp_ready_i(rsp_ready), .rsp_o(rsp),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  // Model state
  wstd_pkg::task_t lring [wstd_pkg::MaxWorkers][wstd_pkg::LocalDepth];
  int unsigned     lhead [wstd_pkg::MaxWorkers];
  int unsigned     lcnt  [wstd_pkg::MaxWorkers];
  wstd_pkg::task_t oring [wstd_pkg::OverflowDepth];
  int unsigned     ohead, ocnt;
  logic [3:0]      workers_reg;

  wstd_pkg::req_t pending_reqs[$];
  wstd_pkg::rsp_t expected_rsps[$];
  int   errors, cycles, n_fetch_hit, n_steal, n_ovf, n_rej;
  bit   rx_stall_done, no_idle, hold_off_rx;

  function automatic wstd_pkg::rsp_t dispatch(wstd_pkg::req_t r);
    wstd_pkg::rsp_t o;
    int unsigned n, w, c;
    wstd_pkg::task_t t;
    o = '0;
    n = (workers_reg == 0) ? 1 :
        (workers_reg > wstd_pkg::MaxWorkers) ? wstd_pkg::MaxWorkers : workers_reg;
    w = r.worker_id;
    t = '{r.task_function, r.task_argument, r.stage};
    if (r.opcode == wstd_pkg::OpSubmit) begin
      if (w >= n) begin
        o.status = wstd_pkg::StRejected;
      end else if (lcnt[w] < wstd_pkg::LocalDepth) begin
        o.queue_depth = 9'(lcnt[w]);
        lring[w][(lhead[w] + lcnt[w]) % wstd_pkg::LocalDepth] = t;
        lcnt[w]++;
        o.status = wstd_pkg::StLocalPush;
      end else if (ocnt < wstd_pkg::OverflowDepth) begin
        o.queue_depth = 9'(ocnt);
        oring[(ohead + ocnt) % wstd_pkg::OverflowDepth] = t;
        ocnt++;
        o.status = wstd_pkg::StOvfPush;
        n_ovf++;
      end else begin
        o.queue_depth = 9'(ocnt);
        o.status = wstd_pkg::StRejected;
        n_rej++;
      end
      return o;
    end
    o.status = wstd_pkg::StNone;
    if (w >= n) return o;
    if (lcnt[w] != 0) begin
      c = lcnt[w] - 1;
      t = lring[w][(lhead[w] + c) % wstd_pkg::LocalDepth];
      lcnt[w] = c;
      o.status = wstd_pkg::StOwnPop;
    end else if (ocnt != 0) begin
      t = oring[ohead];
      ohead = (ohead + 1) % wstd_pkg::OverflowDepth;
      ocnt--;
      o.status = wstd_pkg::StOvfPop;
    end else begin
      for (int v = 0; v < n; v++) begin
        if (v != w && lcnt[v] != 0) begin
          t = lring[v][lhead[v]];
          lhead[v] = (lhead[v] + 1) % wstd_pkg::LocalDepth;
          lcnt[v]--;
          o.status = wstd_pkg::StStolen;
          n_steal++;
          break;
        end
      end
    end
    if (o.status != wstd_pkg::StNone) begin
      o.task_function_res = t.task_function;
      o.task_argument_res = t.task_argument;
      o.stage_res = t.stage;
      n_fetch_hit++;
    end
    return o;
  endfunction

  function automatic wstd_pkg::req_t make_req(logic op, int w, bit edge_vals);
    wstd_pkg::req_t r;
    r.opcode = op;
    r.worker_id = 3'(w);
    r.task_function = edge_vals ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0) : 16'($urandom);
    r.task_argument = edge_vals ? ($urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0) : $urandom;
    r.stage = 3'($urandom_range(0, 7));
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: present queued requests, idle in random bursts
  int tx_gap;
  bit tx_pause;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_valid <= 1'b0;
      req <= '0;
      tx_gap <= 0;
    end else begin
      if (req_valid && req_ready) expected_rsps.push_back(dispatch(req));
      if (!req_valid || req_ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          req_valid <= 1'b0;
        end else if (!tx_pause && pending_reqs.size() > 0) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          if (!no_idle && $urandom_range(0, 9) == 0) tx_gap <= $urandom_range(1, 18);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted on its own
  int rx_hold;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rx_hold <= 0;
    end else if (hold_off_rx && !rx_stall_done) begin
      if (rx_hold == 300) rx_stall_done <= 1'b1;
      rx_hold <= rx_hold + 1;
    end
  end

  // Monitor: compare each result with the oldest prediction
  int rx_gap;
  wstd_pkg::rsp_t exp_r;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_ready <= 1'b0;
      rx_gap <= 0;
    end else begin
      cycles <= cycles + 1;
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("result with nothing expected: %p", rsp);
          errors++;
        end else begin
          exp_r = expected_rsps.pop_front();
          if (rsp.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, rsp.status); errors++;
          end
          if (rsp.task_function_res !== exp_r.task_function_res) begin
            $error("task_function_res exp %h got %h", exp_r.task_function_res,
                   rsp.task_function_res); errors++;
          end
          if (rsp.task_argument_res !== exp_r.task_argument_res) begin
            $error("task_argument_res exp %h got %h", exp_r.task_argument_res,
                   rsp.task_argument_res); errors++;
          end
          if (rsp.stage_res !== exp_r.stage_res) begin
            $error("stage_res exp %0d got %0d", exp_r.stage_res, rsp.stage_res);
            errors++;
          end
          if (rsp.queue_depth !== exp_r.queue_depth) begin
            $error("queue_depth exp %0d got %0d", exp_r.queue_depth, rsp.queue_depth);
            errors++;
          end
        end
      end
      if (hold_off_rx && !rx_stall_done) begin
        // hold off so the block backs up and stalls its input
        rsp_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        rsp_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        rx_gap <= $urandom_range(0, 17);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
      if (cycles > 2000000) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic drain();
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (req_valid || expected_rsps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_workers(logic [3:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    workers_reg = v;
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed traffic: bias submits when filling, fetches when draining
  task automatic random_phase(int count, int submit_pct, int wmax);
    for (int i = 0; i < count; i++)
      pending_reqs.push_back(make_req($urandom_range(0, 99) >= submit_pct,
                                      $urandom_range(0, wmax), $urandom_range(0, 15) == 0));
  endtask

  initial begin
    req_valid = 0; rsp_ready = 0; cfg_valid = 0; cfg_data = '0; req = '0;
    errors = 0; cycles = 0; n_fetch_hit = 0; n_steal = 0; n_ovf = 0; n_rej = 0;
    tx_pause = 0; no_idle = 0; hold_off_rx = 0; rx_stall_done = 0;
    workers_reg = 4'd8; ohead = 0; ocnt = 0;
    foreach (lhead[i]) begin lhead[i] = 0; lcnt[i] = 0; end
    rst_n = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // Directed: empty fetch, extremes, own pop, steal, inactive workers
    pending_reqs.push_back(make_req(wstd_pkg::OpFetch, 0, 1));
    pending_reqs.push_back(make_req(wstd_pkg::OpSubmit, 7, 1));
    pending_reqs.push_back(make_req(wstd_pkg::OpSubmit, 7, 1));
    pending_reqs.push_back(make_req(wstd_pkg::OpSubmit, 3, 1));
    pending_reqs.push_back(make_req(wstd_pkg::OpFetch, 7, 0));
    pending_reqs.push_back(make_req(wstd_pkg::OpFetch, 0, 0));
    pending_reqs.push_back(make_req(wstd_pkg::OpFetch, 0, 0));
    pending_reqs.push_back(make_req(wstd_pkg::OpFetch, 0, 0));
    write_workers(4'd1);
    pending_reqs.push_back(make_req(wstd_pkg::OpSubmit, 5, 1));
    pending_reqs.push_back(make_req(wstd_pkg::OpFetch, 5, 0));
    pending_reqs.push_back(make_req(wstd_pkg::OpSubmit, 0, 1));
    pending_reqs.push_back(make_req(wstd_pkg::OpFetch, 0, 0));
    write_workers(4'd0);
    pending_reqs.push_back(make_req(wstd_pkg::OpSubmit, 1, 0));
    pending_reqs.push_back(make_req(wstd_pkg::OpFetch, 0, 0));
    write_workers(4'd15);

    // Fill worker 0 past its ring into overflow and beyond; long output stall
    hold_off_rx = 1;
    for (int i = 0; i < 390; i++) pending_reqs.push_back(make_req(wstd_pkg::OpSubmit, 0, 0));
    drain();
    hold_off_rx = 0;
    // Worker 0 pops its ring, then the overflow ring in FIFO order, shared with worker 1
    random_phase(300, 0, 0);
    for (int i = 0; i < 20; i++) pending_reqs.push_back(make_req(wstd_pkg::OpFetch, 1, 0));
    random_phase(100, 0, 0);
    pending_reqs.push_back(make_req(wstd_pkg::OpFetch, 2, 0));
    pending_reqs.push_back(make_req(wstd_pkg::OpFetch, 2, 0));

    // Sender waits for every result before continuing
    tx_pause = 1;
    wait (expected_rsps.size() == 0 && !req_valid);
    tx_pause = 0;

    write_workers(4'd3);
    random_phase(100, 60, 7);
    write_workers(4'd8);
    random_phase(120, 65, 7);
    random_phase(100, 25, 7);
    write_workers(4'd5);
    random_phase(100, 55, 7);
    no_idle = 1;
    random_phase(80, 50, 7);
    drain();

    $display("Covered %0d successful fetches, %0d steals, %0d overflow pushes, %0d rejects",
             n_fetch_hit, n_steal, n_ovf, n_rej);
    $display("across worker counts 0,1,3,5,8,15 with random stalls on both channels.");
    if (errors == 0 && expected_rsps.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule

FILE: filelist.f
src/wstd_pkg.sv
src/wstd_ram.sv
src/wstd_ctrl.sv
src/work_stealing_task_dispatcher_core.sv
tb/tb.sv
